### design/assert_macros.svh
// Assertion helpers included by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with asynchronous active-low reset disable
`define CHK_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### design/wsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, reset values and codes of the world-to-screen projection.
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int POS_W     = 24;
	localparam int COEF_IN_W = 32;
	localparam int WIN_W     = 14;
	localparam int PIX_W     = 16;
	localparam int QBITS     = 17;
	localparam int CLIP_LAT  = 4;
	localparam int PIX_LAT   = QBITS + 5;

	localparam logic [WIN_W-1:0] WIDTH_RST  = 14'd1920;
	localparam logic [WIN_W-1:0] HEIGHT_RST = 14'd1080;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	localparam logic [QBITS-1:0] PIX_POS_LIM = 17'd32767;
	localparam logic [QBITS-1:0] PIX_NEG_LIM = 17'd32768;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [WIN_W-1:0] win_t;
	typedef logic signed [PIX_W-1:0] pix_t;

endpackage
`default_nettype wire

### design/wsp_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_clip
// Matrix store and four-stage clip-space transform (rows 0, 1 and 3).
// ----------------------------------------------------------------------------
module wsp_clip #(
	parameter int CW = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               load,
	input  wire logic [3:0]                         coef_index,
	input  wire logic signed [wsp_pkg::COEF_IN_W-1:0] coef_value,
	input  wire wsp_pkg::pos_t                      pos_x,
	input  wire wsp_pkg::pos_t                      pos_y,
	input  wire wsp_pkg::pos_t                      pos_z,
	output logic signed [wsp_pkg::POS_W+CW+2:0]     num_x_s4,
	output logic signed [wsp_pkg::POS_W+CW+2:0]     num_y_s4,
	output logic [wsp_pkg::POS_W+CW+2:0]            den_s4,
	output logic                                    vis_s4
);
	localparam int PROD_W = wsp_pkg::POS_W + CW;
	localparam int CLIP_W = PROD_W + 2;
	localparam int NUM_W  = CLIP_W + 1;
	localparam int TEN_W  = CLIP_W + 4;
	localparam logic signed [TEN_W-1:0] VIS_MIN = TEN_W'(1) << 24;

	logic signed [CW-1:0]     mat_q [16];
	logic signed [PROD_W-1:0] px_s1 [3];
	logic signed [PROD_W-1:0] py_s1 [3];
	logic signed [PROD_W-1:0] pz_s1 [3];
	logic signed [CW-1:0]     tr_s1 [3];
	logic signed [CLIP_W-1:0] sa_s2 [3];
	logic signed [CLIP_W-1:0] sb_s2 [3];
	logic signed [CLIP_W-1:0] clip_s3 [3];
	logic signed [TEN_W-1:0]  ten_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else if (load) begin
			mat_q[coef_index] <= coef_value[CW-1:0];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_row
		localparam int B = (g == 2) ? 12 : g * 4;
		always_ff @(posedge clk) begin
			if (en) begin
				px_s1[g]   <= pos_x * mat_q[B];
				py_s1[g]   <= pos_y * mat_q[B+1];
				pz_s1[g]   <= pos_z * mat_q[B+2];
				tr_s1[g]   <= mat_q[B+3];
				sa_s2[g]   <= CLIP_W'(px_s1[g]) + CLIP_W'(py_s1[g]);
				// translation word rescaled from Q16.16 to 24 fraction bits
				sb_s2[g]   <= CLIP_W'(pz_s1[g]) + (CLIP_W'(tr_s1[g]) <<< 8);
				clip_s3[g] <= sa_s2[g] + sb_s2[g];
			end
		end
	end

	// 10*w >= 2^24 is the exact form of w >= 0.1
	assign ten_w = (TEN_W'(clip_s3[2]) <<< 3) + (TEN_W'(clip_s3[2]) <<< 1);

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s4 <= NUM_W'(clip_s3[2]) + NUM_W'(clip_s3[0]);
			num_y_s4 <= NUM_W'(clip_s3[2]) - NUM_W'(clip_s3[1]);
			den_s4   <= NUM_W'(clip_s3[2]) <<< 1;
			vis_s4   <= ten_w >= VIS_MIN;
		end
	end

endmodule
`default_nettype wire

### design/wsp_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pixel
// Pipelined floor(scale*num/den) with 16-bit saturation, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module wsp_pixel #(
	parameter int NUM_W = 59
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire wsp_pkg::win_t            scale,
	input  wire logic signed [NUM_W-1:0]  num,
	input  wire logic [NUM_W-1:0]         den,
	output wsp_pkg::pix_t                 pix
);
	localparam int WW    = wsp_pkg::WIN_W;
	localparam int QB    = wsp_pkg::QBITS;
	localparam int LO_W  = NUM_W / 2;
	localparam int HI_W  = NUM_W - LO_W;
	localparam int N_W   = NUM_W + WW + 1;
	localparam int W2    = N_W + QB;

	logic [WW+LO_W-1:0]          plo_p1;
	logic signed [WW+HI_W:0]     phi_p1;
	logic [NUM_W-1:0]            den_p1, den_p2, den_p3;
	logic                        neg_p1, neg_p2, neg_p3;
	logic signed [N_W-1:0]       n_p2;
	logic [N_W-1:0]              a_p3;

	logic [N_W-1:0]   rem_d [QB+1];
	logic [QB-1:0]    q_d   [QB+1];
	logic [NUM_W-1:0] den_d [QB+1];
	logic             neg_d [QB+1];
	logic             ovf_d [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			plo_p1 <= scale * num[LO_W-1:0];
			phi_p1 <= $signed({1'b0, scale}) * $signed(num[NUM_W-1:LO_W]);
			neg_p1 <= num[NUM_W-1];
			den_p1 <= den;
			n_p2   <= (N_W'(phi_p1) <<< LO_W) + N_W'($signed({1'b0, plo_p1}));
			neg_p2 <= neg_p1;
			den_p2 <= den_p1;
			// floor of a negative ratio: -ceil(|n|/d), and ~n + d = |n| + d - 1
			a_p3   <= neg_p2 ? (~n_p2 + N_W'(den_p2)) : n_p2;
			neg_p3 <= neg_p2;
			den_p3 <= den_p2;
			rem_d[0] <= a_p3;
			q_d[0]   <= '0;
			den_d[0] <= den_p3;
			neg_d[0] <= neg_p3;
			ovf_d[0] <= W2'(a_p3) >= (W2'(den_p3) << QB);
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		localparam int B = QB - k;
		logic [W2-1:0] sub_w;
		logic          ge_w;
		assign sub_w = W2'(den_d[k-1]) << B;
		assign ge_w  = W2'(rem_d[k-1]) >= sub_w;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[k]   <= ge_w ? N_W'(W2'(rem_d[k-1]) - sub_w) : rem_d[k-1];
				q_d[k]     <= q_d[k-1] | (QB'(ge_w) << B);
				den_d[k]   <= den_d[k-1];
				neg_d[k]   <= neg_d[k-1];
				ovf_d[k]   <= ovf_d[k-1];
			end
		end
	end

	logic [QB-1:0] q_neg_w;
	assign q_neg_w = ~q_d[QB] + QB'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_d[QB]) begin
				if (ovf_d[QB] || q_d[QB] > wsp_pkg::PIX_NEG_LIM) pix <= 16'sh8000;
				else pix <= q_neg_w[wsp_pkg::PIX_W-1:0];
			end else begin
				if (ovf_d[QB] || q_d[QB] > wsp_pkg::PIX_POS_LIM) pix <= 16'sh7fff;
				else pix <= q_d[QB][wsp_pkg::PIX_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### design/world_to_screen_projection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while the result word is not held; load
// words update the matrix at once and give no result. The 17-step restoring
// divider sets the depth.
// Reset: matrix cleared to zero, window 1920 x 1080, pipeline empty.
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects Q15.8 points through a stored Q16.16 matrix to pixel coordinates.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module world_to_screen_projection_unit #(
	parameter int COEF_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 src_valid,
	output logic                                      src_stall,
	input  wire logic                                 op,
	input  wire logic [3:0]                           coef_index,
	input  wire logic signed [wsp_pkg::COEF_IN_W-1:0] coef_value,
	input  wire wsp_pkg::pos_t                        pos_x,
	input  wire wsp_pkg::pos_t                        pos_y,
	input  wire wsp_pkg::pos_t                        pos_z,
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output logic                                      visible,
	output wsp_pkg::pix_t                             screen_x,
	output wsp_pkg::pix_t                             screen_y,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic                                 cfg_index,
	input  wire wsp_pkg::win_t                        cfg_data
);
	localparam int CW    = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
	localparam int NUM_W = wsp_pkg::POS_W + CW + 3;
	localparam int PL    = wsp_pkg::PIX_LAT;
	localparam int LAT   = wsp_pkg::CLIP_LAT + PL;

	logic                     en;
	logic                     load;
	logic [LAT-1:0]           vld_q;
	logic [PL-1:0]            vis_q;
	wsp_pkg::win_t            wwid_q, whgt_q;
	logic signed [NUM_W-1:0]  num_x_s4, num_y_s4;
	logic [NUM_W-1:0]         den_s4;
	logic                     vis_s4;
	wsp_pkg::pix_t            pix_x, pix_y;

	// whole pipe advances unless the output word is held
	assign en        = !(res_valid && res_stall);
	assign src_stall = !en;
	assign load      = src_valid && en && (op == wsp_pkg::OP_LOAD);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wwid_q <= wsp_pkg::WIDTH_RST;
			whgt_q <= wsp_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == wsp_pkg::CFG_WIDTH) wwid_q <= cfg_data;
			else whgt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], src_valid && (op == wsp_pkg::OP_PROJECT)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) vis_q <= {vis_q[PL-2:0], vis_s4};
	end

	wsp_clip #(.CW(CW)) u_clip (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.load       (load),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.num_x_s4   (num_x_s4),
		.num_y_s4   (num_y_s4),
		.den_s4     (den_s4),
		.vis_s4     (vis_s4)
	);

	wsp_pixel #(.NUM_W(NUM_W)) u_pix_x (
		.clk   (clk),
		.en    (en),
		.scale (wwid_q),
		.num   (num_x_s4),
		.den   (den_s4),
		.pix   (pix_x)
	);

	wsp_pixel #(.NUM_W(NUM_W)) u_pix_y (
		.clk   (clk),
		.en    (en),
		.scale (whgt_q),
		.num   (num_y_s4),
		.den   (den_s4),
		.pix   (pix_y)
	);

	assign res_valid = vld_q[LAT-1];
	assign visible   = vis_q[PL-1];
	assign screen_x  = visible ? pix_x : '0;
	assign screen_y  = visible ? pix_y : '0;

	`CHK_AT(a_hidden_zero, clk, arst_n,
		(res_valid && !visible) |-> (screen_x == '0 && screen_y == '0),
		"hidden point with nonzero coordinates")
	`CHK_NEXT(a_load_no_result, clk, arst_n,
		src_valid && !src_stall && (op == wsp_pkg::OP_LOAD), !vld_q[0],
		"load word entered the result pipe")
	`CHK_NEXT(a_hold_on_stall, clk, arst_n, !en, $stable(vld_q),
		"pipeline moved while output held")

endmodule
`default_nettype wire

### verif/world_to_screen_projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_checker
// Watches the point, result and register channels of the projection unit,
// keeps its own matrix and window size, computes the expected pixel words
// and compares them with what the unit returns.
// ----------------------------------------------------------------------------
module world_to_screen_projection_checker #(
	parameter int COEF_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	input  logic                 src_stall,
	input  logic                 op,
	input  logic [3:0]           coef_index,
	input  logic signed [31:0]   coef_value,
	input  wsp_pkg::pos_t        pos_x,
	input  wsp_pkg::pos_t        pos_y,
	input  wsp_pkg::pos_t        pos_z,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  logic                 visible,
	input  wsp_pkg::pix_t        screen_x,
	input  wsp_pkg::pix_t        screen_y,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic                 cfg_index,
	input  wsp_pkg::win_t        cfg_data,
	output int                   errors,
	output int                   pending,
	output int                   n_results,
	output int                   n_hidden
);
	import wsp_pkg::*;

	typedef struct packed {
		logic vis;
		pix_t sx;
		pix_t sy;
	} pixel_word_t;

	logic signed [63:0] matrix [16];
	win_t win_w, win_h;
	pixel_word_t pixel_q[$];

	function automatic logic signed [63:0] narrow_coef(logic signed [31:0] v);
		logic signed [63:0] r;
		r = v;
		if (COEF_WIDTH < 32) begin
			r = v << (64 - COEF_WIDTH);
			r = r >>> (64 - COEF_WIDTH);
		end
		return r;
	endfunction

	// floor(s*num/den), den > 0, saturated to 16 bits
	function automatic pix_t scale_pixel(win_t s, logic signed [63:0] num,
			logic signed [63:0] den);
		logic signed [127:0] p, q, r;
		if (s == 0)
			return '0;
		p = $signed({1'b0, s}) * num;
		q = p / den;
		r = p % den;
		if (r < 0)
			q = q - 1;
		if (q > 32767)
			return 16'sd32767;
		if (q < -32768)
			return -16'sd32768;
		return q[15:0];
	endfunction

	function automatic logic signed [63:0] clip_row(int k, pos_t x, pos_t y, pos_t z);
		return x * matrix[k] + y * matrix[k+1] + z * matrix[k+2] + matrix[k+3] * 256;
	endfunction

	function automatic pixel_word_t project_point(pos_t x, pos_t y, pos_t z);
		logic signed [63:0] cx, cy, cw;
		pixel_word_t w;
		cx = clip_row(0, x, y, z);
		cy = clip_row(4, x, y, z);
		cw = clip_row(12, x, y, z);
		w = '0;
		if (cw * 10 >= (64'sd1 <<< 24)) begin
			w.vis = 1'b1;
			w.sx = scale_pixel(win_w, cw + cx, 2 * cw);
			w.sy = scale_pixel(win_h, cw - cy, 2 * cw);
		end
		return w;
	endfunction

	assign pending = pixel_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_word_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				matrix[i] = 0;
			win_w = WIDTH_RST;
			win_h = HEIGHT_RST;
			pixel_q.delete();
			errors = 0;
			n_results = 0;
			n_hidden = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: result word with none expected: %b %0d %0d",
						$time, visible, screen_x, screen_y);
					errors++;
				end else begin
					e = pixel_q.pop_front();
					n_results++;
					if (!e.vis)
						n_hidden++;
					if (visible !== e.vis || screen_x !== e.sx || screen_y !== e.sy) begin
						$display("%0t: mismatch exp vis=%b x=%0d y=%0d got vis=%b x=%0d y=%0d",
							$time, e.vis, e.sx, e.sy, visible, screen_x, screen_y);
						errors++;
					end
				end
			end
			if (src_valid && !src_stall) begin
				if (op == OP_LOAD)
					matrix[coef_index] = narrow_coef(coef_value);
				else
					pixel_q.push_back(project_point(pos_x, pos_y, pos_z));
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WIDTH)
					win_w = cfg_data;
				else
					win_h = cfg_data;
			end
		end
	end
endmodule

### verif/world_to_screen_projection_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit_tb
// Loads matrices and window sizes, streams points with random gaps and
// backpressure, and leaves the checking to the checker module.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit_tb;
	import wsp_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk, arst_n;
	logic src_valid, src_stall, op;
	logic [3:0] coef_index;
	logic signed [31:0] coef_value;
	pos_t pos_x, pos_y, pos_z;
	logic res_valid, res_stall, visible;
	pix_t screen_x, screen_y;
	logic cfg_valid, cfg_ready, cfg_index;
	win_t cfg_data;
	int errors, pending, n_results, n_hidden;
	int idle_cycles, n_points;
	bit hold_off;

	world_to_screen_projection_unit u_top (.*);
	world_to_screen_projection_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// word sender: one word, random gap afterwards
	task automatic send_word(logic o, logic [3:0] idx, logic signed [31:0] v,
			pos_t x, pos_t y, pos_t z);
		int gap;
		op <= o; coef_index <= idx; coef_value <= v;
		pos_x <= x; pos_y <= y; pos_z <= z;
		src_valid <= 1'b1;
		do @(posedge clk); while (src_stall);
		if (o == OP_PROJECT)
			n_points++;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 1)) gap = 0;
		@(negedge clk);
		if (gap > 0) begin
			src_valid <= 1'b0;
			op <= ~o; coef_value <= $urandom; pos_x <= pos_t'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic load_coef(int idx, logic signed [31:0] v);
		send_word(OP_LOAD, idx[3:0], v, pos_t'($urandom), pos_t'($urandom),
			pos_t'($urandom));
	endtask

	task automatic project(pos_t x, pos_t y, pos_t z);
		send_word(OP_PROJECT, 4'($urandom), $urandom, x, y, z);
	endtask

	task automatic write_reg(logic idx, win_t v);
		cfg_index <= idx; cfg_data <= v; cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, then wait until the pipeline is empty
	task automatic drain;
		src_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (PIX_LAT + CLIP_LAT + 4) @(negedge clk);
	endtask

	// a perspective-like matrix with random content; w mostly positive
	task automatic load_camera;
		for (int i = 0; i < 16; i++) begin
			logic signed [31:0] v;
			v = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			if (i == 14) v = $urandom_range(1 << 14, 1 << 17);
			if (i == 15) v = $signed($urandom_range(0, 1 << 20)) - (1 << 16);
			if ($urandom_range(0, 15) == 0) v = $urandom;
			load_coef(i, v);
		end
	endtask

	function automatic pos_t rand_pos();
		case ($urandom_range(0, 3))
			0: return pos_t'($urandom);
			1: return pos_t'($signed(24'($urandom_range(0, 1 << 14))) - (1 << 13));
			default: return pos_t'($signed(24'($urandom_range(0, 1 << 18))) - (1 << 17));
		endcase
	endfunction

	// receiver stall, with one long hold-off
	initial begin
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
				res_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(0, 18)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else if (++idle_cycles >= WATCHDOG) begin
				$display("Watchdog expired after %0d idle cycles", WATCHDOG);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		win_t sizes [6];
		sizes = '{14'd1, 14'd8192, 14'd0, 14'd16383, 14'd640, 14'd1920};
		n_points = 0;
		hold_off = 0;
		arst_n = 0; src_valid = 0; op = OP_LOAD; coef_index = 0; coef_value = 0;
		pos_x = 0; pos_y = 0; pos_z = 0; cfg_valid = 0; cfg_index = CFG_WIDTH;
		cfg_data = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: zero matrix gives w=0, hidden; then extremes
		project(24'sh7FFFFF, -24'sh800000, 0);
		load_coef(15, 32'sd6553);                    // w just below 0.1
		project(0, 0, 0);
		load_coef(15, 32'sd6553 + 1);                // w just above 0.1
		project(0, 0, 0);
		load_coef(0, 32'sh7FFFFFFF);
		load_coef(5, 32'sh80000000);
		load_coef(15, 32'sd65536);
		project(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		project(-24'sh800000, -24'sh800000, -24'sh800000);
		load_coef(12, 32'sh80000000);
		project(-24'sh800000, 0, 0);
		project(24'sh7FFFFF, 0, 0);
		load_coef(12, 0);
		load_coef(3, 32'sh00010000);
		load_coef(7, -32'sh00010000);
		project(1, -1, 0);
		project(0, 0, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_WIDTH, sizes[ph]);
			write_reg(CFG_HEIGHT, sizes[(ph + 3) % 6]);
			load_camera();
			for (int i = 0; i < 250; i++) begin
				if (ph == 2 && i == 20) hold_off = 1'b1;
				if ($urandom_range(0, 15) == 0)
					load_coef($urandom_range(0, 15), $urandom);
				else
					project(rand_pos(), rand_pos(), rand_pos());
			end
			drain();
		end
		write_reg(CFG_WIDTH, WIDTH_RST);
		write_reg(CFG_HEIGHT, HEIGHT_RST);
		drain();
		$display("Projected %0d points, %0d results checked, %0d of them not visible",
			n_points, n_results, n_hidden);
		$display("Covered six window size settings incl. 0, 1 and full width");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### sim.f
+incdir+design
design/wsp_pkg.sv
design/wsp_clip.sv
design/wsp_pixel.sv
design/world_to_screen_projection_unit.sv
verif/world_to_screen_projection_checker.sv
verif/world_to_screen_projection_unit_tb.sv
